// ===== hdl/clps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clps_pkg: shared types and constants for the control loop statistics block
// Beat layouts, queue entry, back end states and saturating helpers.
// ----------------------------------------------------------------------------
package clps_pkg;

    // Default geometry
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 32;

    // Accumulator and report datapath widths
    localparam int ACC_W   = 64;
    localparam int SCALE_W = 14;                 // 10000 < 2^14
    localparam int DIV_W   = ACC_W + SCALE_W;    // scaled dividend width
    localparam int ROOT_W  = ACC_W / 2;

    // Entry slots in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Kind codes of the input beat
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Result field caps
    localparam logic [15:0] PEAK_CAP   = 16'd32768;
    localparam logic [15:0] RMS_CAP    = 16'd32768;
    localparam logic [21:0] EFFORT_CAP = 22'd3276800;
    localparam logic [15:0] JITTER_CAP = 16'd65535;
    localparam logic [30:0] ITAE_CAP   = 31'h7FFF_FFFF;

    // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4, applied as shift-adds
    localparam int SCALE_TERMS = 5;
    localparam int unsigned SCALE_SHIFT [SCALE_TERMS] = '{13, 10, 9, 8, 4};

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_REPORT,
        OP_CLEAR
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR_DIV,
        ST_ERR_SQRT,
        ST_SCALE,
        ST_EFF_DIV,
        ST_EFF_SQRT,
        ST_JIT_DIV,
        ST_ITAE_DIV,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] error;
        logic signed [15:0] drive;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] peak_error;
        logic [15:0] err_rms;
        logic [21:0] effort;
        logic [15:0] jitter;
        logic [30:0] itae_mean;
    } out_beat_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] error;
        logic [15:0] drive;
    } qentry_t;

    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } qhead_t;

    // Add two accumulator values, sticking at all ones on overflow
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/control_loop_performance_stats.sv =====
`default_nettype none
// Sample and clear beats: one per cycle sustained while no report is running; applied as they leave the queue head.
// Report beats: four 78-step restoring divisions, two 32-step square roots and a 5-step
//   scaling by 10000 (none when the count is zero), then a load of the output register.
// The output register lets samples keep being applied while a result waits to be taken.
// Reset (aresetn low, synchronous) clears all statistics, the queue and the output valid.
// ----------------------------------------------------------------------------
// control_loop_performance_stats: control loop RMS, jitter and ITAE metrics
// Front queue of classified beats feeding an accumulator and report engine.
// ----------------------------------------------------------------------------
module control_loop_performance_stats #(
    parameter int SAMPLE_WIDTH = clps_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = clps_pkg::COUNT_WIDTH_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  clps_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output clps_pkg::out_beat_t  m_data
);

    clps_pkg::qhead_t head;
    logic             pop;

    clps_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .pop     (pop),
        .head    (head)
    );

    clps_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ===== hdl/clps_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clps_front: input acceptance and classification
// Takes input beats, drops unused kinds and queues operations for the back.
// ----------------------------------------------------------------------------
module clps_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  clps_pkg::in_beat_t  s_data,
    input  wire                 pop,
    output clps_pkg::qhead_t    head
);

    localparam int PTR_W = $clog2(clps_pkg::QUEUE_DEPTH);
    localparam int LVL_W = $clog2(clps_pkg::QUEUE_DEPTH + 1);

    clps_pkg::qentry_t slot_reg [clps_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]  level_reg, level_next;

    clps_pkg::qentry_t entry;
    logic              known;
    logic              push;
    logic              take;

    // Classify the beat kind
    always_comb begin
        entry.error = s_data.error;
        entry.drive = s_data.drive;
        known       = 1'b1;
        case (s_data.kind)
            clps_pkg::KIND_SAMPLE: entry.op = clps_pkg::OP_SAMPLE;
            clps_pkg::KIND_REPORT: entry.op = clps_pkg::OP_REPORT;
            clps_pkg::KIND_CLEAR:  entry.op = clps_pkg::OP_CLEAR;
            default: begin
                entry.op = clps_pkg::OP_SAMPLE;
                known    = 1'b0;
            end
        endcase
    end

    assign s_ready = (level_reg != LVL_W'(clps_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready && known;
    assign take    = pop && (level_reg != '0);

    assign head.valid = (level_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];

    // Advance pointers and level
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !take) begin
            level_next = level_reg + 1'b1;
        end else if (take && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store the queued operation
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/clps_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clps_div: restoring divider, one quotient bit per cycle
// Divides an accumulator, or its scaled form, by the sample count.
// ----------------------------------------------------------------------------
module clps_div #(
    parameter int COUNT_WIDTH = clps_pkg::COUNT_WIDTH_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          go,
    input  wire [clps_pkg::DIV_W-1:0]    dividend,
    input  wire [COUNT_WIDTH-1:0]        divisor,
    output logic                         done,
    output logic [clps_pkg::DIV_W-1:0]   quotient
);

    localparam int DW    = clps_pkg::DIV_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] dsr_reg, dsr_next;
    logic [DW-1:0]          quo_reg, quo_next;

    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   fits;

    // Trial subtract of the shifted remainder
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = !diff[COUNT_WIDTH];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (busy_reg) begin
            rem_next = fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (go && !done_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== hdl/clps_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clps_isqrt: digit-by-digit integer square root
// Floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module clps_isqrt (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           go,
    input  wire [clps_pkg::ACC_W-1:0]     radicand,
    output logic                          done,
    output logic [clps_pkg::ROOT_W-1:0]   root
);

    localparam int AW = clps_pkg::ACC_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [AW-1:0] n_reg, n_next;
    logic [AW-1:0] res_reg, res_next;
    logic [AW-1:0] bit_reg, bit_next;

    logic [AW-1:0] trial;
    logic          fits;

    assign trial = res_reg + bit_reg;
    assign fits  = (n_reg >= trial);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (busy_reg) begin
            if (fits) begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (go && !done_reg) begin
            busy_next = 1'b1;
            n_next    = radicand;
            res_next  = '0;
            bit_next  = AW'(1) << (AW - 2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[clps_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== hdl/clps_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clps_back: statistics accumulators and report sequencer
// Applies samples and clears, and runs reports through divider and root.
// ----------------------------------------------------------------------------
module clps_back #(
    parameter int SAMPLE_WIDTH = clps_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = clps_pkg::COUNT_WIDTH_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  clps_pkg::qhead_t     head,
    output logic                 pop,
    output logic                 m_valid,
    input  wire                  m_ready,
    output clps_pkg::out_beat_t  m_data
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = COUNT_WIDTH;
    localparam int AW    = clps_pkg::ACC_W;
    localparam int DW    = clps_pkg::DIV_W;
    localparam int RW    = clps_pkg::ROOT_W;
    localparam int PW    = (CW + SW > AW) ? CW + SW : AW + 1;
    localparam int IDX_W = $clog2(clps_pkg::SCALE_TERMS);

    clps_pkg::back_state_t state_reg, state_next;

    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    esq_reg, esq_next;
    logic [AW-1:0]    dsq_reg, dsq_next;
    logic [AW-1:0]    dlt_reg, dlt_next;
    logic [AW-1:0]    itae_reg, itae_next;
    logic [SW-1:0]    peak_reg, peak_next;
    logic [SW-1:0]    prev_reg, prev_next;

    logic [DW-1:0]    scaled_reg, scaled_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      rms_reg, rms_next;
    logic [21:0]      effort_reg, effort_next;
    logic [15:0]      jitter_reg, jitter_next;
    logic [30:0]      itae_res_reg, itae_res_next;

    logic                 m_valid_reg, m_valid_next;
    clps_pkg::out_beat_t  m_data_reg, m_data_next;

    // Sample datapath
    logic [SW-1:0]   e_raw, d_raw, ae, ad;
    logic [2*SW-1:0] esq_term, dsq_term;
    logic [SW:0]     dd, dd_abs;
    logic [PW-1:0]   itae_prod;
    logic [AW-1:0]   itae_term;

    // Report units
    logic            div_go, div_done;
    logic [DW-1:0]   dividend, quotient;
    logic            sqrt_go, sqrt_done;
    logic [AW-1:0]   radicand;
    logic [RW-1:0]   root;
    logic            out_free;

    assign e_raw     = SW'(head.entry.error);
    assign d_raw     = SW'(head.entry.drive);
    assign ae        = e_raw[SW-1] ? (~e_raw + 1'b1) : e_raw;
    assign ad        = d_raw[SW-1] ? (~d_raw + 1'b1) : d_raw;
    assign esq_term  = ae * ae;
    assign dsq_term  = ad * ad;
    assign dd        = {d_raw[SW-1], d_raw} - {prev_reg[SW-1], prev_reg};
    assign dd_abs    = dd[SW] ? (~dd + 1'b1) : dd;
    assign itae_prod = PW'(count_reg) * PW'(ae);
    assign itae_term = (|itae_prod[PW-1:AW]) ? {AW{1'b1}} : itae_prod[AW-1:0];

    assign out_free  = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            clps_pkg::ST_IDLE: begin
                if (head.valid && head.entry.op == clps_pkg::OP_REPORT) begin
                    state_next = (count_reg == '0) ? clps_pkg::ST_OUT
                                                   : clps_pkg::ST_ERR_DIV;
                end
            end
            clps_pkg::ST_ERR_DIV: begin
                if (div_done) state_next = clps_pkg::ST_ERR_SQRT;
            end
            clps_pkg::ST_ERR_SQRT: begin
                if (sqrt_done) state_next = clps_pkg::ST_SCALE;
            end
            clps_pkg::ST_SCALE: begin
                if (idx_reg == IDX_W'(clps_pkg::SCALE_TERMS - 1)) begin
                    state_next = clps_pkg::ST_EFF_DIV;
                end
            end
            clps_pkg::ST_EFF_DIV: begin
                if (div_done) state_next = clps_pkg::ST_EFF_SQRT;
            end
            clps_pkg::ST_EFF_SQRT: begin
                if (sqrt_done) state_next = clps_pkg::ST_JIT_DIV;
            end
            clps_pkg::ST_JIT_DIV: begin
                if (div_done) state_next = clps_pkg::ST_ITAE_DIV;
            end
            clps_pkg::ST_ITAE_DIV: begin
                if (div_done) state_next = clps_pkg::ST_OUT;
            end
            clps_pkg::ST_OUT: begin
                if (out_free) state_next = clps_pkg::ST_IDLE;
            end
            default: state_next = clps_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        pop      = 1'b0;
        div_go   = 1'b0;
        sqrt_go  = 1'b0;
        dividend = DW'(esq_reg);
        radicand = quotient[AW-1:0];
        case (state_reg)
            clps_pkg::ST_IDLE:     pop = head.valid;
            clps_pkg::ST_ERR_DIV:  div_go = 1'b1;
            clps_pkg::ST_ERR_SQRT: sqrt_go = 1'b1;
            clps_pkg::ST_EFF_DIV: begin
                div_go   = 1'b1;
                dividend = scaled_reg;
            end
            clps_pkg::ST_EFF_SQRT: begin
                sqrt_go  = 1'b1;
                radicand = (|quotient[DW-1:AW]) ? {AW{1'b1}} : quotient[AW-1:0];
            end
            clps_pkg::ST_JIT_DIV: begin
                div_go   = 1'b1;
                dividend = DW'(dlt_reg);
            end
            clps_pkg::ST_ITAE_DIV: begin
                div_go   = 1'b1;
                dividend = DW'(itae_reg);
            end
            default: ;
        endcase
    end

    // Accumulators, report results and output register
    always_comb begin
        count_next    = count_reg;
        esq_next      = esq_reg;
        dsq_next      = dsq_reg;
        dlt_next      = dlt_reg;
        itae_next     = itae_reg;
        peak_next     = peak_reg;
        prev_next     = prev_reg;
        scaled_next   = scaled_reg;
        idx_next      = idx_reg;
        rms_next      = rms_reg;
        effort_next   = effort_reg;
        jitter_next   = jitter_reg;
        itae_res_next = itae_res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            clps_pkg::ST_IDLE: begin
                if (head.valid) begin
                    case (head.entry.op)
                        clps_pkg::OP_SAMPLE: begin
                            esq_next  = clps_pkg::sat_add(esq_reg, AW'(esq_term));
                            dsq_next  = clps_pkg::sat_add(dsq_reg, AW'(dsq_term));
                            itae_next = clps_pkg::sat_add(itae_reg, itae_term);
                            if (ae > peak_reg) peak_next = ae;
                            if (count_reg != '0) begin
                                dlt_next = clps_pkg::sat_add(dlt_reg, AW'(dd_abs));
                            end
                            prev_next = d_raw;
                            if (!(&count_reg)) count_next = count_reg + 1'b1;
                        end
                        clps_pkg::OP_CLEAR: begin
                            count_next = '0;
                            esq_next   = '0;
                            dsq_next   = '0;
                            dlt_next   = '0;
                            itae_next  = '0;
                            peak_next  = '0;
                            prev_next  = '0;
                        end
                        clps_pkg::OP_REPORT: begin
                            scaled_next   = '0;
                            idx_next      = '0;
                            rms_next      = '0;
                            effort_next   = '0;
                            jitter_next   = '0;
                            itae_res_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            clps_pkg::ST_ERR_SQRT: begin
                if (sqrt_done) begin
                    rms_next = (root > RW'(clps_pkg::RMS_CAP)) ? clps_pkg::RMS_CAP
                                                              : root[15:0];
                end
            end
            clps_pkg::ST_SCALE: begin
                scaled_next = scaled_reg + (DW'(dsq_reg) << clps_pkg::SCALE_SHIFT[idx_reg]);
                idx_next    = idx_reg + 1'b1;
            end
            clps_pkg::ST_EFF_SQRT: begin
                if (sqrt_done) begin
                    effort_next = (root > RW'(clps_pkg::EFFORT_CAP)) ? clps_pkg::EFFORT_CAP
                                                                    : root[21:0];
                end
            end
            clps_pkg::ST_JIT_DIV: begin
                if (div_done) begin
                    jitter_next = (|quotient[DW-1:16]) ? clps_pkg::JITTER_CAP
                                                       : quotient[15:0];
                end
            end
            clps_pkg::ST_ITAE_DIV: begin
                if (div_done) begin
                    itae_res_next = (|quotient[DW-1:31]) ? clps_pkg::ITAE_CAP
                                                         : quotient[30:0];
                end
            end
            clps_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.peak_error = (AW'(peak_reg) > AW'(clps_pkg::PEAK_CAP))
                                             ? clps_pkg::PEAK_CAP : 16'(peak_reg);
                    m_data_next.err_rms    = rms_reg;
                    m_data_next.effort     = effort_reg;
                    m_data_next.jitter     = jitter_reg;
                    m_data_next.itae_mean  = itae_res_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= clps_pkg::ST_IDLE;
            count_reg   <= '0;
            esq_reg     <= '0;
            dsq_reg     <= '0;
            dlt_reg     <= '0;
            itae_reg    <= '0;
            peak_reg    <= '0;
            prev_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            esq_reg     <= esq_next;
            dsq_reg     <= dsq_next;
            dlt_reg     <= dlt_next;
            itae_reg    <= itae_next;
            peak_reg    <= peak_next;
            prev_reg    <= prev_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scaled_reg   <= scaled_next;
        rms_reg      <= rms_next;
        effort_reg   <= effort_next;
        jitter_reg   <= jitter_next;
        itae_res_reg <= itae_res_next;
        m_data_reg   <= m_data_next;
    end

    clps_div #(
        .COUNT_WIDTH (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (div_go),
        .dividend (dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    clps_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (sqrt_go),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (root)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== hdl/clps_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clps_checker: port-level checks for the statistics block
// Watches the result channel for hold behavior, reset and field ranges.
// ----------------------------------------------------------------------------
module clps_checker (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  m_valid,
    input wire                  m_ready,
    input clps_pkg::out_beat_t  m_data
);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Drop valid after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Keep peak and rms fields in range
    a_range_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.peak_error <= clps_pkg::PEAK_CAP) &&
                    (m_data.err_rms <= clps_pkg::RMS_CAP))
        else $error("error field out of range");

    // Keep effort in range
    a_range_eff: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.effort <= clps_pkg::EFFORT_CAP))
        else $error("effort field out of range");

endmodule

bind control_loop_performance_stats clps_checker u_clps_checker (.*);
`default_nettype wire

// ===== tb/tb_control_loop_performance_stats.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_control_loop_performance_stats: self-checking bench for the loop metrics
// Random and directed sample, report and clear beats drive the block; a local
// model of the statistics predicts every report, checked field by field.
// ----------------------------------------------------------------------------
module tb_control_loop_performance_stats;

    localparam longint unsigned ACC_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam longint unsigned COUNT_TOP = 64'hFFFF_FFFF;
    localparam longint unsigned TIMEOUT   = 4_000_000;
    localparam logic [1:0]      KIND_NONE = 2'd3;   // unused kind, dropped by the block

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    clps_pkg::in_beat_t s_data;
    logic m_valid;
    logic m_ready;
    clps_pkg::out_beat_t m_data;

    control_loop_performance_stats dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Statistics state of the predictor
    longint unsigned st_count, st_esq, st_peak, st_dsq, st_delta, st_itae;
    logic signed [15:0] st_prev;

    clps_pkg::in_beat_t  pending_beats[$];
    clps_pkg::out_beat_t expected_reports[$];
    int  mismatches = 0;
    bit  calm;
    longint unsigned cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s < a) ? ACC_MAX : s;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned clip(longint unsigned v, longint unsigned hi);
        return (v > hi) ? hi : v;
    endfunction

    function automatic longint unsigned mag(longint signed v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    task automatic clear_stats();
        st_count = 0; st_esq = 0; st_peak = 0; st_dsq = 0;
        st_delta = 0; st_itae = 0; st_prev = '0;
    endtask

    // Fold one accepted beat into the statistics; queue a report if asked
    task automatic update_stats(clps_pkg::in_beat_t b);
        longint unsigned ae, ad, q, r, m, prod;
        clps_pkg::out_beat_t o;
        case (b.kind)
            clps_pkg::KIND_SAMPLE: begin
                ae = mag(longint'(b.error));
                ad = mag(longint'(b.drive));
                st_esq = add_sat(st_esq, ae * ae);
                if (ae > st_peak) st_peak = ae;
                st_dsq = add_sat(st_dsq, ad * ad);
                if (st_count > 0)
                    st_delta = add_sat(st_delta,
                        mag(longint'(b.drive) - longint'(st_prev)));
                st_prev = b.drive;
                if (st_count != 0 && ae > ACC_MAX / st_count) prod = ACC_MAX;
                else prod = st_count * ae;
                st_itae = add_sat(st_itae, prod);
                if (st_count < COUNT_TOP) st_count++;
            end
            clps_pkg::KIND_REPORT: begin
                o = '0;
                if (st_count != 0) begin
                    o.peak_error = 16'(clip(st_peak, clps_pkg::PEAK_CAP));
                    o.err_rms    = 16'(clip(root_floor(st_esq / st_count),
                                        clps_pkg::RMS_CAP));
                    q = st_dsq / st_count;
                    r = st_dsq % st_count;
                    if (q > (ACC_MAX - 10000) / 10000) begin
                        o.effort = clps_pkg::EFFORT_CAP;
                    end else begin
                        m = q * 10000 + (r * 10000) / st_count;
                        o.effort = 22'(clip(root_floor(m), clps_pkg::EFFORT_CAP));
                    end
                    o.jitter    = 16'(clip(st_delta / st_count, clps_pkg::JITTER_CAP));
                    o.itae_mean = 31'(clip(st_itae / st_count, clps_pkg::ITAE_CAP));
                end
                expected_reports.push_back(o);
            end
            clps_pkg::KIND_CLEAR: clear_stats();
            default: ;
        endcase
    endtask

    // Drive beats from the pending queue, idling now and then
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) update_stats(s_data);
            if (!(s_valid && !s_ready)) begin
                if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
                    s_data  <= pending_beats.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check each result beat against the oldest expected report
    always @(posedge aclk) begin
        clps_pkg::out_beat_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 9);
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected report %h", m_data);
                end else begin
                    e = expected_reports.pop_front();
                    if (e.peak_error !== m_data.peak_error || e.err_rms !== m_data.err_rms
                        || e.effort !== m_data.effort || e.jitter !== m_data.jitter
                        || e.itae_mean !== m_data.itae_mean) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"report mismatch: exp %0d %0d %0d %0d %0d",
                                      " got %0d %0d %0d %0d %0d"},
                                e.peak_error, e.err_rms, e.effort, e.jitter, e.itae_mean,
                                m_data.peak_error, m_data.err_rms, m_data.effort,
                                m_data.jitter, m_data.itae_mean);
                    end
                end
            end
        end
    end

    // Timeout guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles > TIMEOUT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic clps_pkg::in_beat_t mk(logic [1:0] k, logic [15:0] e,
                                              logic [15:0] d);
        clps_pkg::in_beat_t b;
        b.kind = k; b.error = e; b.drive = d;
        return b;
    endfunction

    function automatic logic [15:0] rand_val();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(16) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int n;
        clps_pkg::in_beat_t b;
        aresetn = 1'b0;
        calm = 0;
        clear_stats();

        // Directed: empty report, extremes, unused kind, clear
        pending_beats.push_back(mk(clps_pkg::KIND_REPORT, 16'd0, 16'd0));
        pending_beats.push_back(mk(clps_pkg::KIND_SAMPLE, 16'h8000, 16'h8000));
        pending_beats.push_back(mk(clps_pkg::KIND_REPORT, 16'd0, 16'd0));
        pending_beats.push_back(mk(clps_pkg::KIND_SAMPLE, 16'h7FFF, 16'h7FFF));
        pending_beats.push_back(mk(clps_pkg::KIND_SAMPLE, 16'hFFFF, 16'h8000));
        pending_beats.push_back(mk(clps_pkg::KIND_SAMPLE, 16'h0000, 16'h0000));
        pending_beats.push_back(mk(KIND_NONE, 16'h1234, 16'h5678));
        pending_beats.push_back(mk(clps_pkg::KIND_REPORT, 16'hFFFF, 16'hFFFF));
        pending_beats.push_back(mk(clps_pkg::KIND_CLEAR, 16'hFFFF, 16'hFFFF));
        pending_beats.push_back(mk(clps_pkg::KIND_REPORT, 16'd0, 16'd0));
        pending_beats.push_back(mk(clps_pkg::KIND_SAMPLE, 16'h0001, 16'hFFFF));
        pending_beats.push_back(mk(clps_pkg::KIND_REPORT, 16'd0, 16'd0));
        pending_beats.push_back(mk(clps_pkg::KIND_CLEAR, 16'd0, 16'd0));

        // Random: runs of samples broken by reports, occasional clears and noise
        n = 0;
        while (n < 1200) begin
            case ($urandom_range(99)) inside
                [0:83]:  b = mk(clps_pkg::KIND_SAMPLE, rand_val(), rand_val());
                [84:93]: b = mk(clps_pkg::KIND_REPORT, 16'($urandom), 16'($urandom));
                [94:97]: b = mk(clps_pkg::KIND_CLEAR, 16'($urandom), 16'($urandom));
                default: b = mk(KIND_NONE, 16'($urandom), 16'($urandom));
            endcase
            pending_beats.push_back(b);
            n++;
        end
        pending_beats.push_back(mk(clps_pkg::KIND_REPORT, 16'd0, 16'd0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Long stretch with no idling in the middle of the run
        wait (pending_beats.size() < 700);
        calm = 1;
        wait (pending_beats.size() < 400);
        calm = 0;

        wait (pending_beats.size() == 0);
        @(posedge aclk);
        while (s_valid) @(posedge aclk);
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
